// ===== sv/plst_pkg.sv =====
`timescale 1ns / 1ps

package plst_pkg;

   // Fixed field widths of the command and response words
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   localparam int ELEM_W   = 32;

   // Cell index bus is sized for the largest supported capacity
   localparam int CELL_IDX_W = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_BACK  = 3'd1,
      MODE_INS_POS   = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_BACK  = 3'd4,
      MODE_DEL_POS   = 3'd5,
      MODE_DUMP      = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type             op;
      logic [CELL_IDX_W-1:0]   sel;
      logic [CELL_IDX_W-1:0]   tail;
   } cell_ctl_type;

endpackage

// ===== sv/plst_if.sv =====
`timescale 1ns / 1ps

interface plst_req_if;
   logic                         valid;
   logic                         ready;
   logic [plst_pkg::MODE_W-1:0]  mode;
   logic [plst_pkg::VALUE_W-1:0] value;
   logic [plst_pkg::POS_W-1:0]   position;

   modport source (output valid, mode, value, position, input ready);
   modport sink (input valid, mode, value, position, output ready);
   modport monitor (input valid, ready, mode, value, position);
endinterface

interface plst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [plst_pkg::STATUS_W-1:0] status;
   logic [plst_pkg::COUNT_W-1:0]  count;
   logic [plst_pkg::ELEM_W-1:0]   element;
   logic                          element_valid;
   logic                          last;

   modport source (output valid, status, count, element, element_valid, last, input ready);
   modport sink (input valid, status, count, element, element_valid, last, output ready);
   modport monitor (input valid, ready, status, count, element, element_valid, last);
endinterface

// ===== sv/plst_cell.sv =====
`timescale 1ns / 1ps

module plst_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  plst_pkg::cell_ctl_type  ctl,
   input  logic [DATA_WIDTH-1:0]   word,
   input  logic [DATA_WIDTH-1:0]   left_data,
   input  logic [DATA_WIDTH-1:0]   right_data,
   input  logic [DATA_WIDTH-1:0]   head_data,
   output logic [DATA_WIDTH-1:0]   data
);

   localparam logic [plst_pkg::CELL_IDX_W-1:0] MY_IDX = INDEX[plst_pkg::CELL_IDX_W-1:0];

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         plst_pkg::OP_INSERT: begin
            // open a slot at sel: cells behind it take the left neighbor
            if (MY_IDX > ctl.sel) begin
               data_in = left_data;
            end else if (MY_IDX == ctl.sel) begin
               data_in = word;
            end
         end
         plst_pkg::OP_DELETE: begin
            if (MY_IDX >= ctl.sel) begin
               data_in = right_data;
            end
         end
         plst_pkg::OP_ROTATE: begin
            // rotate the occupied cells left, head wraps to the tail
            if (MY_IDX < ctl.tail) begin
               data_in = right_data;
            end else if (MY_IDX == ctl.tail) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== sv/positional_list_store.sv =====
`timescale 1ns / 1ps

// Channel   Modport  Word                                         Handshake
// req_ch    sink     mode, value, position                        valid/ready
// rsp_ch    source   status, count, element, element_valid, last  valid/ready
//
// An edit is applied to the cell chain in the cycle it is accepted; its single
// response word waits in a pending register until the output register is free,
// and no new command is taken while a response is pending.
// A dump of n elements streams n words, one per cycle while rsp_ch is not stalled, out
// of the head cell while the chain rotates; it restores the original order when done.
// Reset clears the count and control only; cell contents are not cleared.
// A stalled rsp_ch holds the output word; ready drops while a word is pending.

module positional_list_store #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   plst_req_if.sink   req_ch,
   plst_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   // one spare bit so that count + 1 never wraps in the position check
   localparam int CMP_W = ((CNT_W > plst_pkg::POS_W) ? CNT_W : plst_pkg::POS_W) + 1;
   localparam int IW    = plst_pkg::CELL_IDX_W;

   typedef enum logic {S_IDLE, S_DUMP} state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IW-1:0]            dump_idx_ff, dump_idx_in;
   logic                     pend_v_ff, pend_v_in;
   plst_pkg::status_type     pend_status_ff, pend_status_in;
   logic [CNT_W-1:0]         pend_count_ff, pend_count_in;
   logic                     out_v_ff, out_v_in;
   plst_pkg::status_type     out_status_ff, out_status_in;
   logic [CNT_W-1:0]         out_count_ff, out_count_in;
   logic [DATA_WIDTH-1:0]    out_elem_ff, out_elem_in;
   logic                     out_ev_ff, out_ev_in;
   logic                     out_last_ff, out_last_in;

   plst_pkg::cell_ctl_type   ctl;
   logic [DATA_WIDTH-1:0]    word;
   logic [DATA_WIDTH-1:0]    cell_data [CAPACITY];
   logic                     accept;
   logic                     out_free;
   logic                     full;
   logic [CMP_W-1:0]         pos_c;
   logic [CMP_W-1:0]         cnt_c;
   logic [IW-1:0]            tail_idx;

   assign word     = DATA_WIDTH'(req_ch.value);
   assign req_ch.ready = (state_ff == S_IDLE) && !pend_v_ff;
   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_v_ff || rsp_ch.ready;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign pos_c    = CMP_W'(req_ch.position);
   assign cnt_c    = CMP_W'(count_ff);
   assign tail_idx = IW'(count_ff - CNT_W'(1));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      pend_v_in      = pend_v_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      out_v_in       = out_v_ff;
      out_status_in  = out_status_ff;
      out_count_in   = out_count_ff;
      out_elem_in    = out_elem_ff;
      out_ev_in      = out_ev_ff;
      out_last_in    = out_last_ff;
      ctl.op         = plst_pkg::OP_HOLD;
      ctl.sel        = '0;
      ctl.tail       = tail_idx;

      if (out_v_ff && rsp_ch.ready) begin
         out_v_in = 1'b0;
      end

      // move a pending edit response into the output register
      if (pend_v_ff && out_free) begin
         out_v_in      = 1'b1;
         out_status_in = pend_status_ff;
         out_count_in  = pend_count_ff;
         out_elem_in   = '0;
         out_ev_in     = 1'b0;
         out_last_in   = 1'b1;
         pend_v_in     = 1'b0;
      end

      if (accept) begin
         pend_v_in      = 1'b1;
         pend_status_in = plst_pkg::ST_OK;
         case (plst_pkg::mode_type'(req_ch.mode))
            plst_pkg::MODE_INS_FRONT, plst_pkg::MODE_INS_BACK: begin
               if (full) begin
                  pend_status_in = plst_pkg::ST_FULL;
               end else begin
                  ctl.op   = plst_pkg::OP_INSERT;
                  ctl.sel  = (plst_pkg::mode_type'(req_ch.mode) == plst_pkg::MODE_INS_FRONT)
                             ? '0 : IW'(count_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            plst_pkg::MODE_INS_POS: begin
               if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
                  pend_status_in = plst_pkg::ST_BADPOS;
               end else if (full) begin
                  pend_status_in = plst_pkg::ST_FULL;
               end else begin
                  ctl.op   = plst_pkg::OP_INSERT;
                  ctl.sel  = IW'(pos_c - CMP_W'(1));
                  count_in = count_ff + CNT_W'(1);
               end
            end
            plst_pkg::MODE_DEL_FRONT, plst_pkg::MODE_DEL_BACK: begin
               if (count_ff == '0) begin
                  pend_status_in = plst_pkg::ST_EMPTY;
               end else begin
                  ctl.op   = plst_pkg::OP_DELETE;
                  ctl.sel  = (plst_pkg::mode_type'(req_ch.mode) == plst_pkg::MODE_DEL_FRONT)
                             ? '0 : tail_idx;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            plst_pkg::MODE_DEL_POS: begin
               if (pos_c == '0 || pos_c > cnt_c) begin
                  pend_status_in = plst_pkg::ST_BADPOS;
               end else begin
                  ctl.op   = plst_pkg::OP_DELETE;
                  ctl.sel  = IW'(pos_c - CMP_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end
            end
            plst_pkg::MODE_DUMP: begin
               if (count_ff == '0) begin
                  pend_status_in = plst_pkg::ST_EMPTY;
               end else begin
                  pend_v_in   = 1'b0;
                  state_in    = S_DUMP;
                  dump_idx_in = '0;
               end
            end
            default: begin
               pend_status_in = plst_pkg::ST_OK;
            end
         endcase
         pend_count_in = count_in;
      end

      // stream the head cell and rotate the chain
      if (state_ff == S_DUMP && out_free) begin
         out_v_in      = 1'b1;
         out_status_in = plst_pkg::ST_OK;
         out_count_in  = count_ff;
         out_elem_in   = cell_data[0];
         out_ev_in     = 1'b1;
         out_last_in   = (dump_idx_ff == tail_idx);
         ctl.op        = plst_pkg::OP_ROTATE;
         dump_idx_in   = dump_idx_ff + IW'(1);
         if (dump_idx_ff == tail_idx) begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
      dump_idx_ff    <= dump_idx_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      out_status_ff  <= out_status_in;
      out_count_ff   <= out_count_in;
      out_elem_ff    <= out_elem_in;
      out_ev_ff      <= out_ev_in;
      out_last_ff    <= out_last_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = word;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      plst_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .word       (word),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.status        = out_status_ff;
   assign rsp_ch.count         = 6'(out_count_ff);
   assign rsp_ch.element       = 32'(out_elem_ff);
   assign rsp_ch.element_valid = out_ev_ff;
   assign rsp_ch.last          = out_last_ff;

endmodule

// ===== sv/plst_checker.sv =====
`timescale 1ns / 1ps

module plst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [plst_pkg::STATUS_W-1:0] rsp_status,
   input logic [plst_pkg::COUNT_W-1:0]  rsp_count,
   input logic [plst_pkg::ELEM_W-1:0]   rsp_element,
   input logic                          rsp_element_valid,
   input logic                          rsp_last
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_count) &&
          $stable(rsp_element) && $stable(rsp_element_valid) && $stable(rsp_last)))
      else $error("response word changed while stalled");

   // one command at a time: no accept in the cycle after an accept
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("command accepted back to back");

   a_elem_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_element_valid) |-> (rsp_status == plst_pkg::ST_OK))
      else $error("dump element with error status");

   a_edit_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_element_valid) |-> (rsp_last && rsp_element == '0))
      else $error("edit response not single or element not zero");

endmodule

bind positional_list_store plst_checker u_plst_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_count         (rsp_ch.count),
   .rsp_element       (rsp_ch.element),
   .rsp_element_valid (rsp_ch.element_valid),
   .rsp_last          (rsp_ch.last)
);

// ===== tb/sv/positional_list_store_test.sv =====
`timescale 1ns / 1ps

module positional_list_store_test;

   localparam int CAPACITY      = 32;
   localparam int DATA_WIDTH    = 32;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 250;
   localparam int HOLD_AFTER    = 60;

   // Mode code the block does not define; it must leave the list alone
   localparam logic [plst_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

   typedef struct {
      logic [plst_pkg::MODE_W-1:0]  mode;
      logic [plst_pkg::VALUE_W-1:0] value;
      logic [plst_pkg::POS_W-1:0]   position;
   } command_type;

   typedef struct {
      logic [plst_pkg::STATUS_W-1:0] status;
      logic [plst_pkg::COUNT_W-1:0]  count;
      logic [plst_pkg::ELEM_W-1:0]   element;
      logic                          element_valid;
      logic                          last;
   } answer_type;

   logic clock;
   logic reset;

   plst_req_if req_ch ();
   plst_rsp_if rsp_ch ();

   positional_list_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   command_type                 pending_cmds[$];
   answer_type                  due_answers[$];
   logic [plst_pkg::ELEM_W-1:0] list_words[$];

   int plan_count;
   int cmds_queued;
   int cmds_taken;
   int words_checked;
   int error_count;
   int full_hits;
   int empty_hits;
   int badpos_hits;
   int dump_cmds;
   int send_gap;
   int recv_stall;
   int hold_left;
   int watchdog_cycles;
   bit hold_done;
   bit quiet;
   bit cmd_took;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= 50)
         $display("mismatch on %s: got %0h, want %0h (word %0d)",
                  what, got, want, words_checked);
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Apply one command to the shadow list and queue the words it should produce
   task automatic apply_command(command_type c);
      plst_pkg::status_type st;
      int                   n;
      st = plst_pkg::ST_OK;
      n  = list_words.size();
      case (c.mode)
         plst_pkg::MODE_INS_FRONT, plst_pkg::MODE_INS_BACK: begin
            if (n >= CAPACITY)
               st = plst_pkg::ST_FULL;
            else if (c.mode == plst_pkg::MODE_INS_FRONT)
               list_words.push_front(c.value);
            else
               list_words.push_back(c.value);
         end
         plst_pkg::MODE_INS_POS: begin
            if (c.position < 1 || c.position > n + 1)
               st = plst_pkg::ST_BADPOS;
            else if (n >= CAPACITY)
               st = plst_pkg::ST_FULL;
            else
               list_words.insert(c.position - 1, c.value);
         end
         plst_pkg::MODE_DEL_FRONT, plst_pkg::MODE_DEL_BACK: begin
            if (n == 0)
               st = plst_pkg::ST_EMPTY;
            else if (c.mode == plst_pkg::MODE_DEL_FRONT)
               void'(list_words.pop_front());
            else
               void'(list_words.pop_back());
         end
         plst_pkg::MODE_DEL_POS: begin
            if (c.position < 1 || c.position > n)
               st = plst_pkg::ST_BADPOS;
            else
               list_words.delete(c.position - 1);
         end
         plst_pkg::MODE_DUMP: begin
            dump_cmds++;
            if (n == 0) begin
               st = plst_pkg::ST_EMPTY;
            end else begin
               for (int i = 0; i < n; i++)
                  due_answers.push_back('{plst_pkg::ST_OK, plst_pkg::COUNT_W'(n),
                                          list_words[i], 1'b1, (i == n - 1)});
               return;
            end
         end
         default: ;
      endcase
      case (st)
         plst_pkg::ST_FULL:   full_hits++;
         plst_pkg::ST_EMPTY:  empty_hits++;
         plst_pkg::ST_BADPOS: badpos_hits++;
         default: ;
      endcase
      due_answers.push_back('{st, plst_pkg::COUNT_W'(list_words.size()), '0, 1'b0, 1'b1});
   endtask

   // Queue a command and track the count it leaves, so positions can be aimed
   task automatic plan_item(logic [plst_pkg::MODE_W-1:0] mode,
                            logic [plst_pkg::VALUE_W-1:0] value,
                            logic [plst_pkg::POS_W-1:0] position);
      pending_cmds.push_back('{mode, value, position});
      cmds_queued++;
      case (mode)
         plst_pkg::MODE_INS_FRONT, plst_pkg::MODE_INS_BACK:
            if (plan_count < CAPACITY)
               plan_count++;
         plst_pkg::MODE_INS_POS:
            if (position >= 1 && position <= plan_count + 1 && plan_count < CAPACITY)
               plan_count++;
         plst_pkg::MODE_DEL_FRONT, plst_pkg::MODE_DEL_BACK:
            if (plan_count > 0)
               plan_count--;
         plst_pkg::MODE_DEL_POS:
            if (position >= 1 && position <= plan_count)
               plan_count--;
         default: ;
      endcase
   endtask

   task automatic plan_random(int grow_pct);
      int                           r;
      int                           k;
      int                           hi;
      bit                           grow;
      logic [plst_pkg::MODE_W-1:0]  m;
      logic [plst_pkg::VALUE_W-1:0] v;
      logic [plst_pkg::POS_W-1:0]   p;
      r    = $urandom_range(99);
      k    = $urandom_range(2);
      grow = 1'b0;
      if (r < 8) begin
         m = plst_pkg::MODE_DUMP;
      end else if (r < 8 + grow_pct * 92 / 100) begin
         grow = 1'b1;
         m = (k == 0) ? plst_pkg::MODE_INS_FRONT :
             (k == 1) ? plst_pkg::MODE_INS_BACK : plst_pkg::MODE_INS_POS;
      end else begin
         m = (k == 0) ? plst_pkg::MODE_DEL_FRONT :
             (k == 1) ? plst_pkg::MODE_DEL_BACK : plst_pkg::MODE_DEL_POS;
      end
      r = $urandom_range(9);
      v = (r == 0) ? '0 : (r == 1) ? '1 : plst_pkg::VALUE_W'($urandom);
      // Mostly aim at a legal position; now and then throw anything in range
      hi = grow ? plan_count + 1 : plan_count;
      if (hi > CAPACITY)
         hi = CAPACITY;
      if (hi < 1)
         hi = 1;
      if ($urandom_range(9) == 0)
         p = plst_pkg::POS_W'($urandom_range(CAPACITY));
      else
         p = plst_pkg::POS_W'($urandom_range(hi, 1));
      plan_item(m, v, p);
   endtask

   // Hold the sender until everything sent has been answered
   task automatic drain();
      while (cmds_taken < cmds_queued || due_answers.size() > 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      answer_type want;
      cmd_took = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         apply_command('{req_ch.mode, req_ch.value, req_ch.position});
         cmds_taken++;
         cmd_took = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_answers.size() == 0) begin
            report("unexpected word, status", rsp_ch.status, 0);
         end else begin
            want = due_answers.pop_front();
            if (rsp_ch.status !== want.status)
               report("status", rsp_ch.status, want.status);
            if (rsp_ch.count !== want.count)
               report("count", rsp_ch.count, want.count);
            if (rsp_ch.element !== want.element)
               report("element", rsp_ch.element, want.element);
            if (rsp_ch.element_valid !== want.element_valid)
               report("element_valid", rsp_ch.element_valid, want.element_valid);
            if (rsp_ch.last !== want.last)
               report("last", rsp_ch.last, want.last);
         end
         words_checked++;
      end
   end

   always @(negedge clock) begin
      command_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || cmd_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            nxt = pending_cmds.pop_front();
            req_ch.mode     <= nxt.mode;
            req_ch.value    <= nxt.value;
            req_ch.position <= nxt.position;
            req_ch.valid    <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold while commands keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && cmds_taken >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         recv_stall = pick_gap();
      end
   end

   initial begin
      for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d words still due",
               CYCLE_LIMIT, due_answers.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = '0;
      req_ch.value    = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;
      quiet           = 1'b0;

      // Empty list: dump, deletes and bad positions
      plan_item(plst_pkg::MODE_DUMP, '0, '0);
      plan_item(plst_pkg::MODE_DEL_FRONT, '0, '0);
      plan_item(plst_pkg::MODE_DEL_BACK, '0, '0);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd1);
      plan_item(plst_pkg::MODE_INS_POS, 32'h1234_5678, 6'd0);
      plan_item(plst_pkg::MODE_INS_POS, 32'h1234_5678, 6'd2);
      // Build front, back, middle and end, then dump, delete and try an unused mode
      plan_item(plst_pkg::MODE_INS_FRONT, 32'hFFFF_FFFF, '0);
      plan_item(plst_pkg::MODE_INS_BACK, 32'h0000_0000, '0);
      plan_item(plst_pkg::MODE_INS_POS, 32'hA5A5_A5A5, 6'd2);
      plan_item(plst_pkg::MODE_INS_POS, 32'h5A5A_5A5A, 6'd4);
      plan_item(plst_pkg::MODE_INS_POS, 32'h8000_0001, 6'd1);
      plan_item(plst_pkg::MODE_DUMP, '0, '0);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd0);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd6);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd3);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd4);
      plan_item(plst_pkg::MODE_DEL_FRONT, '0, '0);
      plan_item(plst_pkg::MODE_DEL_BACK, '0, '0);
      plan_item(MODE_UNUSED, 32'hDEAD_BEEF, 6'd1);
      plan_item(plst_pkg::MODE_DUMP, '0, '0);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd1);
      plan_item(plst_pkg::MODE_INS_POS, 32'h0F0F_F0F0, 6'd1);
      plan_item(plst_pkg::MODE_INS_POS, 32'h7777_7777, 6'd32);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      quiet = 1'b1;
      repeat (20) plan_random(70);
      @(negedge clock);
      while (pending_cmds.size() > 0)
         @(negedge clock);
      quiet = 1'b0;
      repeat (30) plan_random(55);

      // Fill to capacity, then poke the full list
      while (plan_count < CAPACITY)
         plan_random(100);
      plan_item(plst_pkg::MODE_INS_FRONT, 32'h1111_1111, '0);
      plan_item(plst_pkg::MODE_INS_BACK, 32'h2222_2222, '0);
      plan_item(plst_pkg::MODE_INS_POS, 32'h3333_3333, 6'd32);
      plan_item(plst_pkg::MODE_INS_POS, 32'h4444_4444, 6'd0);
      plan_item(plst_pkg::MODE_DUMP, '0, '0);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd32);
      plan_item(plst_pkg::MODE_INS_POS, 32'h5555_5555, 6'd32);
      plan_item(plst_pkg::MODE_DUMP, '0, '0);
      drain();

      repeat (40) plan_random(30);
      while (plan_count > 0)
         plan_random(0);
      plan_item(plst_pkg::MODE_DUMP, '0, '0);
      plan_item(plst_pkg::MODE_DEL_FRONT, '0, '0);
      plan_item(plst_pkg::MODE_DEL_POS, '0, 6'd1);
      drain();

      quiet = 1'b1;
      repeat (15) plan_random(50);
      drain();
      quiet = 1'b0;
      repeat (25) plan_random(50);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d response words checked, %0d dumps",
               cmds_taken, words_checked, dump_cmds);
      $display("status cases seen: full %0d, empty %0d, bad position %0d",
               full_hits, empty_hits, badpos_hits);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
